>>> sv/mtgp_pkg.sv
// ============================================================================
// mtgp_pkg: Shared definitions for the goodput predictor.
// Field widths, leaf codes and the per-leaf coefficient table.
// ============================================================================
package mtgp_pkg;

    localparam int PAYLOAD_W = 16;
    localparam int SNR_W     = 11;
    localparam int RSRP_W    = 13;
    localparam int RSRQ_W    = 10;
    localparam int CQI_W     = 4;
    localparam int SPEED_W   = 9;
    localparam int GOODPUT_W = 16;
    localparam int LEAF_W    = 4;

    localparam int COEF_W    = 23;
    localparam int OFS_W     = 31;
    localparam int PROD_W    = 40;
    localparam int ACC_W     = 44;
    localparam int FRAC_W    = 16;
    localparam int RND_W     = ACC_W - FRAC_W;

    localparam logic signed [ACC_W-1:0] ROUND_HALF = ACC_W'(64'sd1 <<< (FRAC_W - 1));
    localparam logic signed [RND_W-1:0] GOODPUT_MAX = RND_W'(32767);
    localparam logic signed [RND_W-1:0] GOODPUT_MIN = -RND_W'(32768);

    localparam logic [PAYLOAD_W-1:0] P_LIM_0   = 16'd579;
    localparam logic [PAYLOAD_W-1:0] P_LIM_1   = 16'd1289;
    localparam logic [PAYLOAD_W-1:0] P_LOW_2   = 16'd1580;
    localparam logic [PAYLOAD_W-1:0] P_LIM_2   = 16'd2106;
    localparam logic [PAYLOAD_W-1:0] P_LIM_3   = 16'd1843;
    localparam logic [PAYLOAD_W-1:0] P_LIM_4   = 16'd4105;
    localparam logic [PAYLOAD_W-1:0] P_LIM_5   = 16'd632;
    localparam logic signed [RSRP_W-1:0] R_GOOD = -13'sd1608;
    localparam logic signed [RSRP_W-1:0] R_FAIR = -13'sd1512;

    typedef enum logic [LEAF_W-1:0] {
        LEAF_0 = 4'd0,
        LEAF_1 = 4'd1,
        LEAF_2 = 4'd2,
        LEAF_3 = 4'd3,
        LEAF_4 = 4'd4,
        LEAF_5 = 4'd5,
        LEAF_6 = 4'd6,
        LEAF_7 = 4'd7,
        LEAF_8 = 4'd8
    } leaf_t;

    typedef struct packed {
        logic signed [COEF_W-1:0] w_payload;
        logic signed [COEF_W-1:0] w_snr;
        logic signed [COEF_W-1:0] w_rsrp;
        logic signed [COEF_W-1:0] w_rsrq;
        logic signed [COEF_W-1:0] w_cqi;
        logic signed [COEF_W-1:0] w_speed;
        logic signed [OFS_W-1:0]  offset;
    } leaf_coef_t;

    // Weights are in 2^-16 output LSB per input LSB; offsets in 2^-16 output LSB.
    function automatic leaf_coef_t leaf_coef(input leaf_t leaf);
        leaf_coef_t c;
        c = '0;
        unique case (leaf)
            LEAF_0:
            begin
                c = '{23'sd53366, 23'sd210, -23'sd9332, 23'sd209610,
                      23'sd912681, 23'sd11651, 31'sd45936017};
            end
            LEAF_1:
            begin
                c = '{23'sd29747, 23'sd210, 23'sd1887, 23'sd182452,
                      23'sd10066, 23'sd22370, 31'sd96068017};
            end
            LEAF_2:
            begin
                c = '{23'sd28138, 23'sd22649, 23'sd2097, 23'sd196084,
                      23'sd860671, 23'sd0, 31'sd127369268};
            end
            LEAF_3:
            begin
                c = '{23'sd1101, 23'sd62600, 23'sd3146, 23'sd369308,
                      -23'sd25166, -23'sd23302, 31'sd165292487};
            end
            LEAF_4:
            begin
                c = '{23'sd7935, 23'sd2726, 23'sd11744, 23'sd493460,
                      -23'sd26844, 23'sd26098, 31'sd233194914};
            end
            LEAF_5:
            begin
                c = '{23'sd804, 23'sd0, 23'sd226912, 23'sd18770,
                      -23'sd130862, 23'sd0, 31'sd438088342};
            end
            LEAF_6:
            begin
                c = '{23'sd3034, 23'sd0, 23'sd479933, 23'sd23383,
                      -23'sd1533438, 23'sd0, 31'sd901761938};
            end
            LEAF_7:
            begin
                c = '{23'sd0, 23'sd83362, 23'sd9542, 23'sd362807,
                      23'sd0, 23'sd0, 31'sd261422580};
            end
            LEAF_8:
            begin
                c = '{23'sd0, 23'sd0, 23'sd438619, 23'sd0,
                      -23'sd3732931, 23'sd0, 31'sd875998845};
            end
            default:
            begin
                c = '0;
            end
        endcase
        return c;
    endfunction

endpackage

>>> sv/mtgp_in_if.sv
// ============================================================================
// mtgp_in_if: Measurement record channel.
// Carries one measurement record per transaction with valid/ready handshake.
// ============================================================================
interface mtgp_in_if;
    logic                                      valid;
    logic                                      ready;
    logic [mtgp_pkg::PAYLOAD_W-1:0]            payload_size;
    logic signed [mtgp_pkg::SNR_W-1:0]         snr_level;
    logic signed [mtgp_pkg::RSRP_W-1:0]        rsrp_level;
    logic signed [mtgp_pkg::RSRQ_W-1:0]        rsrq_level;
    logic [mtgp_pkg::CQI_W-1:0]                channel_quality;
    logic [mtgp_pkg::SPEED_W-1:0]              speed_kmh;

    modport source (
        output valid, payload_size, snr_level, rsrp_level, rsrq_level,
               channel_quality, speed_kmh,
        input  ready
    );

    modport sink (
        input  valid, payload_size, snr_level, rsrp_level, rsrq_level,
               channel_quality, speed_kmh,
        output ready
    );
endinterface

>>> sv/mtgp_out_if.sv
// ============================================================================
// mtgp_out_if: Goodput prediction channel.
// Carries one prediction and its leaf index per transaction.
// ============================================================================
interface mtgp_out_if;
    logic                                   valid;
    logic                                   ready;
    logic signed [mtgp_pkg::GOODPUT_W-1:0]  goodput;
    logic [mtgp_pkg::LEAF_W-1:0]            leaf_index;

    modport source (
        output valid, goodput, leaf_index,
        input  ready
    );

    modport sink (
        input  valid, goodput, leaf_index,
        output ready
    );
endinterface

>>> sv/mtgp_leaf_sel.sv
// ============================================================================
// mtgp_leaf_sel: Model tree leaf selection.
// Tests the guarded leaf conditions in order and returns the first match.
// ============================================================================
module mtgp_leaf_sel (
    input  logic [mtgp_pkg::PAYLOAD_W-1:0]     payload_size,
    input  logic signed [mtgp_pkg::RSRP_W-1:0] rsrp_level,
    output mtgp_pkg::leaf_t                    leaf
);

    logic good;

    assign good = rsrp_level > mtgp_pkg::R_GOOD;

    always_comb
    begin
        if (good && payload_size <= mtgp_pkg::P_LIM_0)
        begin
            leaf = mtgp_pkg::LEAF_0;
        end
        else if (good && payload_size <= mtgp_pkg::P_LIM_1)
        begin
            leaf = mtgp_pkg::LEAF_1;
        end
        else if (good && payload_size > mtgp_pkg::P_LOW_2
                 && payload_size <= mtgp_pkg::P_LIM_2)
        begin
            leaf = mtgp_pkg::LEAF_2;
        end
        else if (good && payload_size <= mtgp_pkg::P_LIM_3)
        begin
            leaf = mtgp_pkg::LEAF_3;
        end
        else if (good && payload_size <= mtgp_pkg::P_LIM_4)
        begin
            leaf = mtgp_pkg::LEAF_4;
        end
        else if (!good && payload_size <= mtgp_pkg::P_LIM_5)
        begin
            leaf = mtgp_pkg::LEAF_5;
        end
        else if (!good)
        begin
            leaf = mtgp_pkg::LEAF_6;
        end
        else if (rsrp_level > mtgp_pkg::R_FAIR)
        begin
            leaf = mtgp_pkg::LEAF_7;
        end
        else
        begin
            leaf = mtgp_pkg::LEAF_8;
        end
    end

endmodule

>>> sv/model_tree_goodput_predictor_unit.sv
// ============================================================================
// model_tree_goodput_predictor_unit: Piecewise linear goodput predictor.
// Selects a model tree leaf and evaluates its fixed-point weighted sum.
// ============================================================================
//
//  Channel   Modport  Transaction
//  -------   -------  ------------------------------------------------------
//  sample    sink     payload, SNR, RSRP, RSRQ, CQI and speed of one record
//  result    source   saturated goodput and leaf index, one per record
//
//  A record is registered with its leaf at acceptance and then passes the
//  product, partial-sum, rounded-total and output registers: multiply,
//  partial sums, final sum with rounding, saturation.
//  One record is accepted every cycle while the result side takes results.
//  When a result waits, all stages hold together; nothing is lost or repeated.
//  Reset clears all valid bits; data registers are not reset.
//
module model_tree_goodput_predictor_unit (
    input  logic        clk,
    input  logic        rst_n,
    mtgp_in_if.sink     sample,
    mtgp_out_if.source  result
);

    logic adv;

    // Stage 1: registered record and chosen leaf.
    mtgp_pkg::leaf_t                         leaf_next;
    logic                                    s1_valid_reg;
    mtgp_pkg::leaf_t                         s1_leaf_reg;
    logic signed [mtgp_pkg::PAYLOAD_W:0]     s1_payload_reg;
    logic signed [mtgp_pkg::SNR_W-1:0]       s1_snr_reg;
    logic signed [mtgp_pkg::RSRP_W-1:0]      s1_rsrp_reg;
    logic signed [mtgp_pkg::RSRQ_W-1:0]      s1_rsrq_reg;
    logic signed [mtgp_pkg::CQI_W:0]         s1_cqi_reg;
    logic signed [mtgp_pkg::SPEED_W:0]       s1_speed_reg;

    // Stage 2: products.
    mtgp_pkg::leaf_coef_t                    coef;
    logic                                    s2_valid_reg;
    mtgp_pkg::leaf_t                         s2_leaf_reg;
    logic signed [mtgp_pkg::PROD_W-1:0]      p_payload_next;
    logic signed [mtgp_pkg::PROD_W-1:0]      p_snr_next;
    logic signed [mtgp_pkg::PROD_W-1:0]      p_rsrp_next;
    logic signed [mtgp_pkg::PROD_W-1:0]      p_rsrq_next;
    logic signed [mtgp_pkg::PROD_W-1:0]      p_cqi_next;
    logic signed [mtgp_pkg::PROD_W-1:0]      p_speed_next;
    logic signed [mtgp_pkg::PROD_W-1:0]      p_payload_reg;
    logic signed [mtgp_pkg::PROD_W-1:0]      p_snr_reg;
    logic signed [mtgp_pkg::PROD_W-1:0]      p_rsrp_reg;
    logic signed [mtgp_pkg::PROD_W-1:0]      p_rsrq_reg;
    logic signed [mtgp_pkg::PROD_W-1:0]      p_cqi_reg;
    logic signed [mtgp_pkg::PROD_W-1:0]      p_speed_reg;
    logic signed [mtgp_pkg::OFS_W-1:0]       s2_ofs_reg;

    // Stage 3: partial sums.
    logic                                    s3_valid_reg;
    mtgp_pkg::leaf_t                         s3_leaf_reg;
    logic signed [mtgp_pkg::ACC_W-1:0]       sum_a_next;
    logic signed [mtgp_pkg::ACC_W-1:0]       sum_b_next;
    logic signed [mtgp_pkg::ACC_W-1:0]       sum_c_next;
    logic signed [mtgp_pkg::ACC_W-1:0]       sum_a_reg;
    logic signed [mtgp_pkg::ACC_W-1:0]       sum_b_reg;
    logic signed [mtgp_pkg::ACC_W-1:0]       sum_c_reg;

    // Stage 4: rounded total.
    logic                                    s4_valid_reg;
    mtgp_pkg::leaf_t                         s4_leaf_reg;
    logic signed [mtgp_pkg::ACC_W-1:0]       total;
    logic signed [mtgp_pkg::RND_W-1:0]       rnd_next;
    logic signed [mtgp_pkg::RND_W-1:0]       rnd_reg;

    // Stage 5: output register.
    logic                                    out_valid_reg;
    mtgp_pkg::leaf_t                         out_leaf_reg;
    logic signed [mtgp_pkg::GOODPUT_W-1:0]   goodput_next;
    logic signed [mtgp_pkg::GOODPUT_W-1:0]   goodput_reg;

    assign adv          = !out_valid_reg || result.ready;
    assign sample.ready = adv;

    mtgp_leaf_sel u_leaf_sel (
        .payload_size (sample.payload_size),
        .rsrp_level   (sample.rsrp_level),
        .leaf         (leaf_next)
    );

    always_comb
    begin
        coef           = mtgp_pkg::leaf_coef(s1_leaf_reg);
        p_payload_next = s1_payload_reg * coef.w_payload;
        p_snr_next     = s1_snr_reg * coef.w_snr;
        p_rsrp_next    = s1_rsrp_reg * coef.w_rsrp;
        p_rsrq_next    = s1_rsrq_reg * coef.w_rsrq;
        p_cqi_next     = s1_cqi_reg * coef.w_cqi;
        p_speed_next   = s1_speed_reg * coef.w_speed;
    end

    always_comb
    begin
        sum_a_next = mtgp_pkg::ACC_W'(p_payload_reg) + mtgp_pkg::ACC_W'(p_snr_reg);
        sum_b_next = mtgp_pkg::ACC_W'(p_rsrp_reg) + mtgp_pkg::ACC_W'(p_rsrq_reg);
        sum_c_next = mtgp_pkg::ACC_W'(p_cqi_reg) + mtgp_pkg::ACC_W'(p_speed_reg)
                   + mtgp_pkg::ACC_W'(s2_ofs_reg);
    end

    // Adding one half and dropping the fraction rounds half toward plus infinity.
    always_comb
    begin
        total    = sum_a_reg + sum_b_reg + sum_c_reg + mtgp_pkg::ROUND_HALF;
        rnd_next = total[mtgp_pkg::ACC_W-1:mtgp_pkg::FRAC_W];
    end

    always_comb
    begin
        if (rnd_reg > mtgp_pkg::GOODPUT_MAX)
        begin
            goodput_next = mtgp_pkg::GOODPUT_MAX[mtgp_pkg::GOODPUT_W-1:0];
        end
        else if (rnd_reg < mtgp_pkg::GOODPUT_MIN)
        begin
            goodput_next = mtgp_pkg::GOODPUT_MIN[mtgp_pkg::GOODPUT_W-1:0];
        end
        else
        begin
            goodput_next = rnd_reg[mtgp_pkg::GOODPUT_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            s4_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_valid_reg  <= sample.valid;
            s2_valid_reg  <= s1_valid_reg;
            s3_valid_reg  <= s2_valid_reg;
            s4_valid_reg  <= s3_valid_reg;
            out_valid_reg <= s4_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_leaf_reg    <= leaf_next;
            s1_payload_reg <= $signed({1'b0, sample.payload_size});
            s1_snr_reg     <= sample.snr_level;
            s1_rsrp_reg    <= sample.rsrp_level;
            s1_rsrq_reg    <= sample.rsrq_level;
            s1_cqi_reg     <= $signed({1'b0, sample.channel_quality});
            s1_speed_reg   <= $signed({1'b0, sample.speed_kmh});

            s2_leaf_reg    <= s1_leaf_reg;
            p_payload_reg  <= p_payload_next;
            p_snr_reg      <= p_snr_next;
            p_rsrp_reg     <= p_rsrp_next;
            p_rsrq_reg     <= p_rsrq_next;
            p_cqi_reg      <= p_cqi_next;
            p_speed_reg    <= p_speed_next;
            s2_ofs_reg     <= coef.offset;

            s3_leaf_reg    <= s2_leaf_reg;
            sum_a_reg      <= sum_a_next;
            sum_b_reg      <= sum_b_next;
            sum_c_reg      <= sum_c_next;

            s4_leaf_reg    <= s3_leaf_reg;
            rnd_reg        <= rnd_next;

            out_leaf_reg   <= s4_leaf_reg;
            goodput_reg    <= goodput_next;
        end
    end

    assign result.valid      = out_valid_reg;
    assign result.goodput    = goodput_reg;
    assign result.leaf_index = out_leaf_reg;

endmodule

>>> tb/sv/model_tree_goodput_predictor_unit_chk.sv
// ============================================================================
// model_tree_goodput_predictor_unit_chk: Goodput prediction checker.
// Watches the record and prediction channels. For every accepted record it
// selects the model tree leaf and evaluates the fixed-point weighted sum. It
// then compares each accepted prediction, field by field, with the oldest
// outstanding one. Mismatch and outstanding counts are handed to the top.
// ============================================================================
module model_tree_goodput_predictor_unit_chk (
    input  logic clk,
    input  logic rst_n,
    mtgp_in_if   sample,
    mtgp_out_if  result,
    output int   mismatches,
    output int   pending
);
    import mtgp_pkg::*;

    typedef struct {
        logic signed [GOODPUT_W-1:0] goodput;
        leaf_t                       leaf;
    } prediction_t;

    prediction_t predictions [$];

    // Columns: payload, SNR, RSRP, RSRQ, CQI, speed, offset.
    longint leaf_weights [0:8][0:6] = '{
        '{53366,   210,   -9332, 209610,   912681,  11651,  45936017},
        '{29747,   210,    1887, 182452,    10066,  22370,  96068017},
        '{28138, 22649,    2097, 196084,   860671,      0, 127369268},
        '{ 1101, 62600,    3146, 369308,   -25166, -23302, 165292487},
        '{ 7935,  2726,   11744, 493460,   -26844,  26098, 233194914},
        '{  804,     0,  226912,  18770,  -130862,      0, 438088342},
        '{ 3034,     0,  479933,  23383, -1533438,      0, 901761938},
        '{    0, 83362,    9542, 362807,        0,      0, 261422580},
        '{    0,     0,  438619,      0, -3732931,      0, 875998845}
    };

    function automatic leaf_t select_leaf(
        input logic [PAYLOAD_W-1:0]     payload,
        input logic signed [RSRP_W-1:0] rsrp
    );
        logic good;
        good = (rsrp > -13'sd1608);
        if (good && payload <= 16'd579)
            return LEAF_0;
        if (good && payload <= 16'd1289)
            return LEAF_1;
        if (good && payload > 16'd1580 && payload <= 16'd2106)
            return LEAF_2;
        if (good && payload <= 16'd1843)
            return LEAF_3;
        if (good && payload <= 16'd4105)
            return LEAF_4;
        if (!good && payload <= 16'd632)
            return LEAF_5;
        if (!good)
            return LEAF_6;
        if (rsrp > -13'sd1512)
            return LEAF_7;
        return LEAF_8;
    endfunction

    function automatic prediction_t expected_prediction(
        input logic [PAYLOAD_W-1:0]     payload,
        input logic signed [SNR_W-1:0]  snr,
        input logic signed [RSRP_W-1:0] rsrp,
        input logic signed [RSRQ_W-1:0] rsrq,
        input logic [CQI_W-1:0]         cqi,
        input logic [SPEED_W-1:0]       speed
    );
        prediction_t pred;
        longint      term [0:5];
        longint      acc;
        longint      rounded;
        logic [3:0]  row;
        logic [2:0]  i;
        pred.leaf = select_leaf(payload, rsrp);
        row = pred.leaf;
        term[0] = longint'(payload);
        term[1] = longint'(snr);
        term[2] = longint'(rsrp);
        term[3] = longint'(rsrq);
        term[4] = longint'(cqi);
        term[5] = longint'(speed);
        acc = leaf_weights[row][3'd6];
        for (i = 3'd0; i < 3'd6; i++)
        begin
            acc = acc + leaf_weights[row][i] * term[i];
        end
        // Round half toward plus infinity onto the 1/256 Mbit/s grid.
        rounded = (acc + 64'sd32768) >>> 16;
        if (rounded > 64'sd32767)
            rounded = 64'sd32767;
        else if (rounded < -64'sd32768)
            rounded = -64'sd32768;
        pred.goodput = rounded[GOODPUT_W-1:0];
        return pred;
    endfunction

    always @(posedge clk)
    begin : watch
        prediction_t want;
        if (rst_n)
        begin
            if (sample.valid && sample.ready)
            begin
                predictions.push_back(expected_prediction(sample.payload_size,
                    sample.snr_level, sample.rsrp_level, sample.rsrq_level,
                    sample.channel_quality, sample.speed_kmh));
            end
            if (result.valid && result.ready)
            begin
                if (predictions.size() == 0)
                begin
                    $display("%0t: expected no transaction, actual goodput %0d leaf %0d",
                             $time, result.goodput, result.leaf_index);
                    mismatches = mismatches + 1;
                end
                else
                begin
                    want = predictions.pop_front();
                    if (result.goodput !== want.goodput)
                    begin
                        $display("%0t: goodput expected %0d, actual %0d",
                                 $time, want.goodput, result.goodput);
                        mismatches = mismatches + 1;
                    end
                    if (result.leaf_index !== want.leaf)
                    begin
                        $display("%0t: leaf_index expected %0d, actual %0d",
                                 $time, want.leaf, result.leaf_index);
                        mismatches = mismatches + 1;
                    end
                end
            end
        end
        pending <= predictions.size();
    end

endmodule

>>> tb/sv/model_tree_goodput_predictor_unit_tb.sv
// ============================================================================
// model_tree_goodput_predictor_unit_tb: Goodput predictor testbench.
// Sends directed records on every leaf boundary and field extreme, then
// random records in three traffic phases with varying idle rates on both
// sides and one long result stall. The checker compares the predictions.
// ============================================================================
module model_tree_goodput_predictor_unit_tb;
    import mtgp_pkg::*;

    localparam int RANDOM_PER_PHASE = 667;

    logic clk = 1'b0;
    logic rst_n;
    int   phase = 0;
    int   mismatches;
    int   pending;

    int payload_edges [0:6] = '{int'(P_LIM_0), int'(P_LIM_1), int'(P_LOW_2),
                                int'(P_LIM_2), int'(P_LIM_3), int'(P_LIM_4),
                                int'(P_LIM_5)};

    mtgp_in_if  sample_ch ();
    mtgp_out_if result_ch ();

    model_tree_goodput_predictor_unit DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .sample (sample_ch),
        .result (result_ch)
    );

    model_tree_goodput_predictor_unit_chk checker_i (
        .clk        (clk),
        .rst_n      (rst_n),
        .sample     (sample_ch),
        .result     (result_ch),
        .mismatches (mismatches),
        .pending    (pending)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    task automatic send_record(input int payload, input int snr, input int rsrp,
                               input int rsrq, input int cqi, input int speed);
        int idle_pct;
        idle_pct = (phase == 0) ? 10 : (phase == 1) ? 87 : 0;
        while ($urandom_range(0, 99) < idle_pct)
        begin
            sample_ch.valid <= 1'b0;
            @(posedge clk);
        end
        sample_ch.valid           <= 1'b1;
        sample_ch.payload_size    <= PAYLOAD_W'(payload);
        sample_ch.snr_level       <= SNR_W'(snr);
        sample_ch.rsrp_level      <= RSRP_W'(rsrp);
        sample_ch.rsrq_level      <= RSRQ_W'(rsrq);
        sample_ch.channel_quality <= CQI_W'(cqi);
        sample_ch.speed_kmh       <= SPEED_W'(speed);
        do
            @(posedge clk);
        while (!sample_ch.ready);
    endtask

    task automatic send_random_record();
        int payload;
        int snr;
        int rsrp;
        int rsrq;
        case ($urandom_range(0, 3))
            0, 1:    payload = payload_edges[3'($urandom_range(0, 6))]
                               + int'($urandom_range(0, 6)) - 3;
            2:       payload = int'($urandom_range(0, 4300));
            default: payload = int'($urandom_range(0, 65535));
        endcase
        case ($urandom_range(0, 4))
            0:       rsrp = int'(R_GOOD) + int'($urandom_range(0, 6)) - 3;
            1:       rsrp = int'(R_FAIR) + int'($urandom_range(0, 6)) - 3;
            2, 3:    rsrp = -int'($urandom_range(0, 2560));
            default: rsrp = int'($urandom_range(0, 8191)) - 4096;
        endcase
        if ($urandom_range(0, 4) != 0)
        begin
            snr  = int'($urandom_range(0, 1535)) - 512;
            rsrq = -int'($urandom_range(0, 512));
        end
        else
        begin
            snr  = int'($urandom_range(0, 2047)) - 1024;
            rsrq = int'($urandom_range(0, 1023)) - 512;
        end
        send_record(payload, snr, rsrp, rsrq, $urandom_range(0, 15),
                    $urandom_range(0, 511));
    endtask

    initial
    begin
        result_ch.ready = 1'b0;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            if (phase == 2)
            begin
                // Long stall while records keep coming, so the pipeline fills up.
                repeat (300)
                begin
                    result_ch.ready <= 1'b0;
                    @(posedge clk);
                end
                phase = 3;
            end
            result_ch.ready <= ($urandom_range(0, 99) >=
                                ((phase == 0) ? 87 : (phase == 1) ? 10 : 0));
            @(posedge clk);
        end
    end

    initial
    begin
        int ph;
        rst_n                     = 1'b0;
        sample_ch.valid           = 1'b0;
        sample_ch.payload_size    = '0;
        sample_ch.snr_level       = '0;
        sample_ch.rsrp_level      = '0;
        sample_ch.rsrq_level      = '0;
        sample_ch.channel_quality = '0;
        sample_ch.speed_kmh       = '0;
        repeat (8)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_record(0, 0, 0, 0, 0, 0);
        send_record(579, 1023, -1607, 0, 15, 511);
        send_record(580, -512, -1607, -512, 0, 0);
        send_record(1289, 1023, 0, 0, 15, 511);
        send_record(1290, -512, -1607, -512, 0, 0);
        send_record(1580, 1023, -100, 0, 15, 511);
        send_record(1581, -512, -1607, -512, 7, 100);
        send_record(2106, 1023, 0, 0, 15, 511);
        send_record(2107, -512, -1607, -512, 0, 0);
        send_record(4105, 1023, 0, 0, 15, 511);
        send_record(4106, 1023, -1511, 0, 15, 511);
        send_record(4106, -512, -1512, -512, 0, 0);
        send_record(65535, 1023, -1607, 0, 15, 511);
        send_record(632, 0, -1608, -256, 8, 60);
        send_record(633, 0, -1608, -256, 8, 60);
        send_record(65535, -512, -2560, -512, 15, 511);
        send_record(0, -1024, -4096, -512, 15, 0);
        send_record(65535, 1023, 4095, 511, 15, 511);
        send_record(65535, 1023, -1608, 0, 0, 511);
        send_record(0, -1024, 4095, -512, 0, 0);
        send_record(4106, 1023, 4095, 511, 15, 511);
        send_record(0, 1023, -4096, 511, 0, 511);

        for (ph = 0; ph < 3; ph++)
        begin
            if (ph > 0)
                phase <= ph;
            repeat (RANDOM_PER_PHASE)
                send_random_record();
        end
        sample_ch.valid <= 1'b0;
        @(posedge clk);
        wait (pending == 0);
        repeat (20)
            @(posedge clk);
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    initial
    begin
        #(20 * 400000);
        $display("Mismatches found");
        $finish;
    end

endmodule

>>> files.f
sv/mtgp_pkg.sv
sv/mtgp_in_if.sv
sv/mtgp_out_if.sv
sv/mtgp_leaf_sel.sv
sv/model_tree_goodput_predictor_unit.sv
tb/sv/model_tree_goodput_predictor_unit_chk.sv
tb/sv/model_tree_goodput_predictor_unit_tb.sv
